FILE: rtl/gcps_pkg.sv
package gcps_pkg;

   localparam int GRID_SIDE        = 128;
   localparam int CHAIN_LIMIT      = 1024;
   localparam int NODE_STORE_BYTES = 65536;

   localparam int GRID_BITS  = $clog2(GRID_SIDE);
   localparam int CELL_BITS  = 2 * GRID_BITS;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int NODE_BITS  = $clog2(NODE_STORE_BYTES);
   localparam int SEEN_BITS  = $clog2(CHAIN_LIMIT + 1);

   localparam int NODE_READS = 12;
   localparam int STEP_BITS  = $clog2(NODE_READS);

   typedef enum logic [1:0] {
      CMD_GRID_WRITE = 2'd0,
      CMD_NODE_WRITE = 2'd1,
      CMD_QUERY      = 2'd2,
      CMD_UNUSED     = 2'd3
   } command_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [15:0]        address;
      logic [15:0]        write_data;
      logic [15:0]        type_mask;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] center_z;
      logic signed [15:0] range_x;
      logic signed [15:0] range_y;
      logic signed [15:0] range_z;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] node_id;
   } rsp_type;

   typedef struct packed {
      logic                 load_query;
      logic                 grid_write;
      logic                 node_write;
      logic                 clear_step;
      logic                 cell_read;
      logic                 head_load;
      logic                 node_read;
      logic [STEP_BITS-1:0] step;
      logic                 advance;
      logic                 cell_next;
      logic                 respond;
      logic                 found;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic head_zero;
      logic match;
      logic next_zero;
      logic seen_last;
      logic last_cell;
   } ctrl_status_type;

   // node byte read order: flags, type word, x, y, z, next id
   function automatic logic [15:0] node_offset(input logic [STEP_BITS-1:0] step);
      logic [15:0] off;
      case (step)
         4'd0:    off = 16'h0018;
         4'd1:    off = 16'h000b;
         4'd2:    off = 16'h001c;
         4'd3:    off = 16'h001d;
         4'd4:    off = 16'h0004;
         4'd5:    off = 16'h0005;
         4'd6:    off = 16'h0006;
         4'd7:    off = 16'h0007;
         4'd8:    off = 16'h0008;
         4'd9:    off = 16'h0009;
         4'd10:   off = 16'h0000;
         4'd11:   off = 16'h0001;
         default: off = 16'h0000;
      endcase
      return off;
   endfunction

endpackage

FILE: rtl/gcps_ctrl.sv
module gcps_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                command,
   output logic                      busy,
   input  gcps_pkg::ctrl_status_type status,
   output gcps_pkg::ctrl_cmd_type    cmd
);
   import gcps_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_CELL  = 8'b0000_0100,
      ST_HEAD  = 8'b0000_1000,
      ST_NEXT  = 8'b0001_0000,
      ST_NODE  = 8'b0010_0000,
      ST_WAIT  = 8'b0100_0000,
      ST_EVAL  = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.step = step_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load_query = 1'b1;
               case (command)
                  CMD_QUERY: state_in = ST_CELL;
                  CMD_GRID_WRITE: begin
                     cmd.grid_write = 1'b1;
                     cmd.respond    = 1'b1;
                  end
                  CMD_NODE_WRITE: begin
                     cmd.node_write = 1'b1;
                     cmd.respond    = 1'b1;
                  end
                  default: cmd.respond = 1'b1;
               endcase
            end
         end
         ST_CELL: begin
            cmd.cell_read = 1'b1;
            state_in      = ST_HEAD;
         end
         ST_HEAD: begin
            if (status.head_zero) begin
               state_in = ST_NEXT;
            end else begin
               cmd.head_load = 1'b1;
               step_in       = '0;
               state_in      = ST_NODE;
            end
         end
         ST_NEXT: begin
            if (status.last_cell) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.cell_next = 1'b1;
               state_in      = ST_CELL;
            end
         end
         ST_NODE: begin
            cmd.node_read = 1'b1;
            if (step_ff == STEP_BITS'(NODE_READS - 1)) state_in = ST_WAIT;
            else step_in = step_ff + 1'b1;
         end
         ST_WAIT: state_in = ST_EVAL;
         ST_EVAL: begin
            if (status.match) begin
               cmd.respond = 1'b1;
               cmd.found   = 1'b1;
               state_in    = ST_IDLE;
            end else if (status.next_zero || status.seen_last) begin
               state_in = ST_NEXT;
            end else begin
               cmd.advance = 1'b1;
               step_in     = '0;
               state_in    = ST_NODE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

FILE: rtl/gcps_datapath.sv
module gcps_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  gcps_pkg::req_type         req,
   input  gcps_pkg::ctrl_cmd_type    cmd,
   output gcps_pkg::ctrl_status_type status,
   output logic                      rsp_valid,
   output gcps_pkg::rsp_type         rsp
);
   import gcps_pkg::*;

   logic [15:0] grid_mem [GRID_CELLS];
   logic [7:0]  node_mem [NODE_STORE_BYTES];

   logic [CELL_BITS-1:0] clr_ff;
   logic [15:0]          gdata_ff;
   logic [7:0]           rdata_ff;
   logic [STEP_BITS-1:0] rstep_ff;
   logic                 rvalid_ff;
   logic [7:0]           nb_ff [NODE_READS];

   logic [15:0]          mask_ff;
   logic signed [17:0]   xlo_ff, xhi_ff, ylo_ff, yhi_ff, zlo_ff, zhi_ff;
   logic [GRID_BITS-1:0] row0_ff, col0_ff;
   logic [1:0]           dr_ff, dc_ff;
   logic [15:0]          id_ff;
   logic [SEEN_BITS-1:0] seen_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   // half ranges truncate toward zero
   logic signed [16:0] hx_sum, hy_sum;
   logic signed [17:0] hrx, hry, cx, cy, cz, rz, vx, vy;
   logic [GRID_BITS-1:0] row, col;
   logic signed [17:0]   nx, ny, nz;
   logic [15:0]          ntype, next_id;

   always_comb begin
      hx_sum = {req.range_x[15], req.range_x} + {16'd0, req.range_x[15]};
      hy_sum = {req.range_y[15], req.range_y} + {16'd0, req.range_y[15]};
      hrx    = 18'(hx_sum >>> 1);
      hry    = 18'(hy_sum >>> 1);
      cx     = 18'(req.center_x);
      cy     = 18'(req.center_y);
      cz     = 18'(req.center_z);
      rz     = 18'(req.range_z);
      vx     = cx - hrx - 18'sd256;
      vy     = cy - hry - 18'sd256;
      row    = row0_ff + GRID_BITS'(dr_ff);
      col    = col0_ff + GRID_BITS'(dc_ff);
      nx     = 18'($signed({nb_ff[5], nb_ff[4]}));
      ny     = 18'($signed({nb_ff[7], nb_ff[6]}));
      nz     = 18'($signed({nb_ff[9], nb_ff[8]}));
      ntype  = {nb_ff[3], nb_ff[2]};
      next_id = {nb_ff[11], nb_ff[10]};
   end

   assign status.clear_last = (clr_ff == CELL_BITS'(GRID_CELLS - 1));
   assign status.head_zero  = (gdata_ff == 16'd0);
   assign status.next_zero  = (next_id == 16'd0);
   assign status.seen_last  = (seen_ff == SEEN_BITS'(CHAIN_LIMIT - 1));
   assign status.last_cell  = (dr_ff == 2'd2) && (dc_ff == 2'd2);
   assign status.match = (nb_ff[0] == 8'd1) && !nb_ff[1][0] && ((ntype & mask_ff) != 16'd0)
                         && (nx >= xlo_ff) && (nx <= xhi_ff)
                         && (ny >= ylo_ff) && (ny <= yhi_ff)
                         && (nz >= zlo_ff) && (nz <= zhi_ff);

   // grid heads: cleared by a sweep after reset
   always_ff @(posedge clock) begin
      if (cmd.clear_step) grid_mem[clr_ff] <= 16'd0;
      else if (cmd.grid_write) grid_mem[req.address[CELL_BITS-1:0]] <= req.write_data;
      if (cmd.cell_read) gdata_ff <= grid_mem[{row, col}];
   end

   always_ff @(posedge clock) begin
      if (cmd.node_write) node_mem[req.address[NODE_BITS-1:0]] <= req.write_data[7:0];
      rdata_ff <= node_mem[NODE_BITS'(id_ff + node_offset(cmd.step))];
   end

   always_ff @(posedge clock) begin
      rstep_ff <= cmd.step;
      if (rvalid_ff && (rstep_ff < STEP_BITS'(NODE_READS))) nb_ff[rstep_ff] <= rdata_ff;
      if (cmd.load_query) begin
         mask_ff <= req.type_mask;
         xlo_ff  <= cx - hrx - 18'sd32;
         xhi_ff  <= cx + hrx + 18'sd32;
         ylo_ff  <= cy - hry - 18'sd32;
         yhi_ff  <= cy + hry + 18'sd32;
         zlo_ff  <= cz - 18'sd256;
         zhi_ff  <= cz + rz;
         col0_ff <= vx[8 +: GRID_BITS];
         row0_ff <= vy[8 +: GRID_BITS];
         dr_ff   <= 2'd0;
         dc_ff   <= 2'd0;
      end else if (cmd.cell_next) begin
         if (dc_ff == 2'd2) begin
            dc_ff <= 2'd0;
            dr_ff <= dr_ff + 2'd1;
         end else begin
            dc_ff <= dc_ff + 2'd1;
         end
      end
      if (cmd.head_load) begin
         id_ff   <= gdata_ff;
         seen_ff <= '0;
      end else if (cmd.advance) begin
         id_ff   <= next_id;
         seen_ff <= seen_ff + 1'b1;
      end
      if (cmd.respond) begin
         rsp_ff.found   <= cmd.found;
         rsp_ff.node_id <= cmd.found ? id_ff : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         rvalid_ff    <= cmd.node_read;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/grid_cell_proximity_search.sv
// Uniform-grid neighbor query. After reset the grid head memory is swept to
// zero, one cell a cycle (GRID_SIDE*GRID_SIDE = 16384 cells), with busy high.
// Write items complete in the idle state. A query loads its bounds, then per
// cell does a head read, a head test and a step to the next cell, plus per node
// examined 12 single-port node byte reads, a wait state and an evaluate state;
// a match ends the walk at that node's test. The result comes out on rsp_valid
// for a single cycle, in the cycle after the item ends; the receiver cannot
// stall it, so it must take every item as it appears.
module grid_cell_proximity_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gcps_pkg::req_type req,
   output logic              rsp_valid,
   output gcps_pkg::rsp_type rsp
);
   import gcps_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   gcps_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req.command),
      .busy    (busy),
      .status  (status),
      .cmd     (cmd)
   );

   gcps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule
